// File: design/assert_macros.svh
// Assertion macros used by the checker in tar_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge of clk outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked at every rising edge of clk outside reset.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/tar_pkg.sv
// Types and constants of the tar record stream parser.
`timescale 1ns / 1ps
`default_nettype none

package tar_pkg;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_DATA,
		PH_PAD,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_DATA,
		KIND_PAD,
		KIND_IGNORED
	} kind_t;

	typedef enum logic [2:0] {
		EV_NONE,
		EV_DIR,
		EV_FILE,
		EV_END,
		EV_ERR
	} event_t;

	localparam logic [8:0] REC_LAST   = 9'd511;
	localparam logic [8:0] SIZE_FIRST = 9'd124;
	localparam logic [8:0] SIZE_LAST  = 9'd134;
	localparam logic [8:0] TYPE_AT    = 9'd156;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] TYPE_FILE  = 8'h30;
	localparam logic [7:0] TYPE_DIR   = 8'h35;

	typedef struct packed {
		logic [7:0]  data_byte;
		kind_t       byte_kind;
		logic [8:0]  record_offset;
		logic        last_data_byte;
		event_t      event_res;
		logic [32:0] file_size;
	} tar_result_t;

endpackage

`default_nettype wire

// File: design/tar_parse_core.sv
// Parser state and per-byte classification logic.
`timescale 1ns / 1ps
`default_nettype none

module tar_parse_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          archive_byte,
	output tar_pkg::tar_result_t result
);
	import tar_pkg::*;

	phase_t      phase_q, phase_d;
	logic [8:0]  byte_position_q, byte_position_d;
	logic [32:0] size_acc_q, size_acc_d;
	logic        size_bad_q, size_bad_d;
	logic [7:0]  type_byte_q, type_byte_d;
	logic        rec_nz_q, rec_nz_d;
	logic        zero_seen_q, zero_seen_d;
	logic [32:0] remaining_q, remaining_d;

	logic        rec_end;
	logic        in_size;
	logic [7:0]  digit;
	logic        digit_ok;
	logic        rec_nz_now;
	logic        last_now;
	event_t      hdr_ev;

	assign rec_end    = (byte_position_q == REC_LAST);
	assign in_size    = (byte_position_q >= SIZE_FIRST) && (byte_position_q <= SIZE_LAST);
	assign digit      = archive_byte - CHAR_ZERO;
	assign digit_ok   = (digit[7:3] == 5'd0);
	assign rec_nz_now = rec_nz_q | (archive_byte != 8'd0);
	assign last_now   = (remaining_q == 33'd1);

	// Verdict on a header record, used on its last byte.
	always_comb begin
		if (type_byte_q == 8'd0) begin
			if (rec_nz_now) begin
				hdr_ev = EV_ERR;
			end else if (zero_seen_q) begin
				hdr_ev = EV_END;
			end else begin
				hdr_ev = EV_NONE;
			end
		end else if (zero_seen_q) begin
			hdr_ev = EV_ERR;
		end else if (type_byte_q == TYPE_DIR) begin
			hdr_ev = EV_DIR;
		end else if ((type_byte_q == TYPE_FILE) && !size_bad_q) begin
			hdr_ev = EV_FILE;
		end else begin
			hdr_ev = EV_ERR;
		end
	end

	// Next state.
	always_comb begin
		phase_d         = phase_q;
		byte_position_d = byte_position_q + 9'd1;
		size_acc_d      = size_acc_q;
		size_bad_d      = size_bad_q;
		type_byte_d     = type_byte_q;
		rec_nz_d        = rec_nz_q;
		zero_seen_d     = zero_seen_q;
		remaining_d     = remaining_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (in_size) begin
					if (digit_ok) begin
						size_acc_d = {size_acc_q[29:0], digit[2:0]};
					end else begin
						size_bad_d = 1'b1;
					end
				end
				if (byte_position_q == TYPE_AT) begin
					type_byte_d = archive_byte;
				end
				rec_nz_d = rec_nz_now;
				if (rec_end) begin
					size_acc_d  = 33'd0;
					size_bad_d  = 1'b0;
					type_byte_d = 8'd0;
					rec_nz_d    = 1'b0;
					unique case (hdr_ev) inside
						EV_ERR, EV_END: begin
							phase_d = PH_DONE;
						end
						EV_FILE: begin
							remaining_d = size_acc_q;
							if (size_acc_q != 33'd0) begin
								phase_d = PH_DATA;
							end
						end
						EV_NONE: begin
							zero_seen_d = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			PH_DATA: begin
				remaining_d = remaining_q - 33'd1;
				if (last_now) begin
					phase_d = rec_end ? PH_HEADER : PH_PAD;
				end
			end
			PH_PAD: begin
				if (rec_end) begin
					phase_d = PH_HEADER;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Result fields.
	always_comb begin
		result.data_byte      = archive_byte;
		result.record_offset  = byte_position_q;
		result.byte_kind      = KIND_IGNORED;
		result.last_data_byte = 1'b0;
		result.event_res      = EV_NONE;
		result.file_size      = 33'd0;
		unique case (phase_q)
			PH_HEADER: begin
				result.byte_kind = KIND_HEADER;
				if (rec_end) begin
					result.event_res = hdr_ev;
					if (hdr_ev == EV_FILE) begin
						result.file_size = size_acc_q;
					end
				end
			end
			PH_DATA: begin
				result.byte_kind      = KIND_DATA;
				result.last_data_byte = last_now;
			end
			PH_PAD: begin
				result.byte_kind = KIND_PAD;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HEADER;
			byte_position_q <= 9'd0;
			size_acc_q      <= 33'd0;
			size_bad_q      <= 1'b0;
			type_byte_q     <= 8'd0;
			rec_nz_q        <= 1'b0;
			zero_seen_q     <= 1'b0;
			remaining_q     <= 33'd0;
		end else if (step) begin
			phase_q         <= phase_d;
			byte_position_q <= byte_position_d;
			size_acc_q      <= size_acc_d;
			size_bad_q      <= size_bad_d;
			type_byte_q     <= type_byte_d;
			rec_nz_q        <= rec_nz_d;
			zero_seen_q     <= zero_seen_d;
			remaining_q     <= remaining_d;
		end
	end

endmodule

`default_nettype wire

// File: design/tar_out_buf.sv
// Two-entry result register with skid stage.
`timescale 1ns / 1ps
`default_nettype none

module tar_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  tar_pkg::tar_result_t push_data,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output tar_pkg::tar_result_t pop_data
);
	import tar_pkg::*;

	tar_result_t main_q, skid_q;
	logic        main_valid_q, skid_valid_q;
	logic        push, load_main;

	assign push_ready = !skid_valid_q;
	assign push       = push_valid && push_ready;
	assign load_main  = !main_valid_q || pop_ready;
	assign pop_valid  = main_valid_q;
	assign pop_data   = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_main) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			main_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: design/tar_record_stream_parser.sv
// Top level of the tar record stream parser.
// Each accepted byte's result is registered; it waits in the skid stage while the result register is held.
// Throughput: one byte per cycle while archive_ready is high; the result register
// and skid stage let a new request be taken while a finished result waits for result_ready.
// Reset: arst_n clears the parser to the header phase at record offset zero
// and empties the result register.
`timescale 1ns / 1ps
`default_nettype none

module tar_record_stream_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        archive_valid,
	output logic        archive_ready,
	input  logic [7:0]  archive_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  data_byte,
	output logic [1:0]  byte_kind,
	output logic [8:0]  record_offset,
	output logic        last_data_byte,
	output logic [2:0]  event_res,
	output logic [32:0] file_size
);
	import tar_pkg::*;

	tar_result_t core_result;
	tar_result_t out_result;
	logic        step;

	assign step = archive_valid && archive_ready;

	tar_parse_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.archive_byte (archive_byte),
		.result       (core_result)
	);

	tar_out_buf u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (archive_valid),
		.push_ready (archive_ready),
		.push_data  (core_result),
		.pop_valid  (result_valid),
		.pop_ready  (result_ready),
		.pop_data   (out_result)
	);

	assign data_byte      = out_result.data_byte;
	assign byte_kind      = out_result.byte_kind;
	assign record_offset  = out_result.record_offset;
	assign last_data_byte = out_result.last_data_byte;
	assign event_res      = out_result.event_res;
	assign file_size      = out_result.file_size;

endmodule

`default_nettype wire

// File: design/tar_chk.sv
// Port-level checker for the tar record stream parser, with its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tar_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        archive_valid,
	input logic        archive_ready,
	input logic [7:0]  archive_byte,
	input logic        result_valid,
	input logic        result_ready,
	input logic [7:0]  data_byte,
	input logic [1:0]  byte_kind,
	input logic [8:0]  record_offset,
	input logic        last_data_byte,
	input logic [2:0]  event_res,
	input logic [32:0] file_size
);
	import tar_pkg::*;

	logic done_q;
	logic take;

	assign take = result_valid && result_ready;

	// Set once a result with an end or error event has been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (take && ((event_res == EV_END) || (event_res == EV_ERR))) begin
			done_q <= 1'b1;
		end
	end

	`ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(data_byte))
	`ASSERT_IMPLIES(a_event_on_last, result_valid && (event_res != EV_NONE), record_offset == REC_LAST && byte_kind == KIND_HEADER)
	`ASSERT_IMPLIES(a_last_is_data, result_valid && last_data_byte, byte_kind == KIND_DATA)
	`ASSERT_IMPLIES(a_size_with_file, result_valid && (event_res != EV_FILE), file_size == 33'd0)
	`ASSERT_IMPLIES(a_ignored_after_end, result_valid && done_q, byte_kind == KIND_IGNORED && event_res == EV_NONE)

endmodule

bind tar_record_stream_parser tar_chk u_chk (.*);

`default_nettype wire

// File: verif/testbench.sv
// Testbench of the tar record stream parser: predicts every parsed byte and checks each result.
`timescale 1ns / 1ps

module testbench;
	import tar_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_AFTER = 700;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_BYTES = 76;
	localparam logic [7:0] TYPE_NONE = 8'h00;

	typedef enum int {
		END_CLEAN,
		END_ZERO_TYPE_DIRTY,
		END_DIRTY_AFTER_ZERO,
		END_UNKNOWN_TYPE,
		END_BAD_DIGIT,
		END_FILE_DATA,
		END_DIR_THEN_ZERO,
		END_TRUNCATED
	} ending_t;

	class record_tracker;
		logic [8:0] offset_next = '0;
		phase_t parse_phase = PH_HEADER;
		logic [32:0] size_sum = '0;
		logic size_bad = 1'b0;
		logic [7:0] type_flag = '0;
		logic header_nonzero = 1'b0;
		logic zero_seen = 1'b0;
		logic [32:0] data_left = '0;
		tar_result_t expected_results[$];
		int failures = 0;

		function void note_archive_byte(logic [7:0] b);
			tar_result_t r;
			logic [7:0] d;
			r.data_byte = b;
			r.byte_kind = KIND_IGNORED;
			r.record_offset = offset_next;
			r.last_data_byte = 1'b0;
			r.event_res = EV_NONE;
			r.file_size = '0;
			case (parse_phase)
				PH_HEADER: begin
					r.byte_kind = KIND_HEADER;
					if (offset_next >= SIZE_FIRST && offset_next <= SIZE_LAST) begin
						d = b - CHAR_ZERO;
						if (d > 8'd7)
							size_bad = 1'b1;
						else
							size_sum = {size_sum[29:0], d[2:0]};
					end
					if (offset_next == TYPE_AT)
						type_flag = b;
					if (b != 8'h00)
						header_nonzero = 1'b1;
					if (offset_next == REC_LAST) begin
						if (type_flag == TYPE_NONE) begin
							if (header_nonzero) begin
								r.event_res = EV_ERR;
								parse_phase = PH_DONE;
							end else if (zero_seen) begin
								r.event_res = EV_END;
								parse_phase = PH_DONE;
							end else begin
								zero_seen = 1'b1;
							end
						end else if (zero_seen) begin
							r.event_res = EV_ERR;
							parse_phase = PH_DONE;
						end else if (type_flag == TYPE_DIR) begin
							r.event_res = EV_DIR;
						end else if (type_flag == TYPE_FILE && !size_bad) begin
							r.event_res = EV_FILE;
							r.file_size = size_sum;
							data_left = size_sum;
							if (size_sum != '0)
								parse_phase = PH_DATA;
						end else begin
							r.event_res = EV_ERR;
							parse_phase = PH_DONE;
						end
						size_sum = '0;
						size_bad = 1'b0;
						type_flag = '0;
						header_nonzero = 1'b0;
					end
				end
				PH_DATA: begin
					r.byte_kind = KIND_DATA;
					data_left = data_left - 33'd1;
					if (data_left == '0) begin
						r.last_data_byte = 1'b1;
						parse_phase = (offset_next == REC_LAST) ? PH_HEADER : PH_PAD;
					end
				end
				PH_PAD: begin
					r.byte_kind = KIND_PAD;
					if (offset_next == REC_LAST)
						parse_phase = PH_HEADER;
				end
				default: begin
				end
			endcase
			offset_next = offset_next + 9'd1;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [32:0] want, logic [32:0] seen);
			if (seen !== want) begin
				$error("%s expected %0d got %0d", name, want, seen);
				failures++;
			end
		endfunction

		function void check_parsed_byte(tar_result_t seen);
			tar_result_t want;
			if (expected_results.size() == 0) begin
				$error("unexpected result with data_byte %0d", seen.data_byte);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("data_byte", want.data_byte, seen.data_byte);
			compare_field("byte_kind", want.byte_kind, seen.byte_kind);
			compare_field("record_offset", want.record_offset, seen.record_offset);
			compare_field("last_data_byte", want.last_data_byte, seen.last_data_byte);
			compare_field("event_res", want.event_res, seen.event_res);
			compare_field("file_size", want.file_size, seen.file_size);
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic archive_valid = 1'b0;
	logic archive_ready;
	logic [7:0] archive_byte = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [7:0] data_byte;
	logic [1:0] byte_kind;
	logic [8:0] record_offset;
	logic last_data_byte;
	logic [2:0] event_res;
	logic [32:0] file_size;

	record_tracker tracker = new();
	bit no_gaps = 1'b0;

	tar_record_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.archive_valid(archive_valid),
		.archive_ready(archive_ready),
		.archive_byte(archive_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.data_byte(data_byte),
		.byte_kind(byte_kind),
		.record_offset(record_offset),
		.last_data_byte(last_data_byte),
		.event_res(event_res),
		.file_size(file_size)
	);

	always #10 clk = ~clk;

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (!no_gaps)
			while ($urandom_range(99) < 22)
				gap++;
		if (gap > 0) begin
			archive_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		archive_valid <= 1'b1;
		archive_byte <= b;
		do @(posedge clk); while (!archive_ready);
		tracker.note_archive_byte(b);
	endtask

	task automatic send_header(input logic [7:0] flag, input logic [32:0] size,
			input bit digits_valid);
		logic [7:0] b;
		int k;
		int bad_at;
		bad_at = digits_valid ? -1 : int'($urandom_range(10));
		for (int i = 0; i < 512; i++) begin
			if (i >= SIZE_FIRST && i <= SIZE_LAST) begin
				k = i - SIZE_FIRST;
				b = CHAR_ZERO + 8'(size[3 * (10 - k) +: 3]);
				if (k == bad_at)
					do b = 8'($urandom); while (b >= CHAR_ZERO && b <= CHAR_ZERO + 8'd7);
			end else if (i == TYPE_AT) begin
				b = flag;
			end else begin
				b = $urandom_range(1) ? 8'($urandom) : 8'h00;
			end
			send_byte(b);
		end
	endtask

	task automatic send_data(input logic [32:0] size);
		for (longint n = 0; n < size; n++)
			send_byte(8'($urandom));
		if (size % 512 != 0)
			for (int p = int'(size % 512); p < 512; p++)
				send_byte($urandom_range(1) ? 8'($urandom) : 8'h00);
	endtask

	task automatic send_zero_record();
		repeat (512) send_byte(8'h00);
	endtask

	task automatic wait_drained();
		archive_valid <= 1'b0;
		do @(posedge clk); while (tracker.pending() != 0);
	endtask

	initial begin : result_sink
		int taken;
		int hold_left;
		taken = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				tracker.check_parsed_byte(tar_result_t'({data_byte, byte_kind, record_offset,
					last_data_byte, event_res, file_size}));
				taken++;
				if (taken == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= no_gaps || ($urandom_range(99) >= 22);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((archive_valid && archive_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("testbench failed");
		$finish;
	end

	initial begin : stimulus
		ending_t ending;
		logic [7:0] odd_flag;
		logic [32:0] data_size;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		data_size = '0;
		ending = ending_t'($urandom_range(END_TRUNCATED));
		case (ending)
			END_CLEAN: send_zero_record();
			END_ZERO_TYPE_DIRTY: send_header(TYPE_NONE, 33'($urandom_range(1, 4000)), 1'b1);
			END_DIRTY_AFTER_ZERO: send_zero_record();
			END_UNKNOWN_TYPE: begin
				do odd_flag = 8'($urandom);
				while (odd_flag == TYPE_NONE || odd_flag == TYPE_FILE || odd_flag == TYPE_DIR);
				send_header(odd_flag, 33'($urandom_range(4000)), 1'b1);
			end
			END_BAD_DIGIT: send_header(TYPE_FILE, 33'($urandom_range(4000)), 1'b0);
			END_FILE_DATA: begin
				data_size = 33'($urandom_range(512));
				send_header(TYPE_FILE, data_size, 1'b1);
			end
			END_DIR_THEN_ZERO:
				send_header(TYPE_DIR, 33'($urandom_range(4000)), 1'($urandom_range(1)));
			default: send_header(TYPE_FILE, '1, 1'b1);
		endcase
		wait_drained();

		no_gaps = 1'b1;
		case (ending)
			END_CLEAN: send_zero_record();
			END_DIRTY_AFTER_ZERO: send_header(TYPE_DIR, '0, 1'b1);
			END_FILE_DATA: begin
				if (data_size == '0)
					send_zero_record();
				else
					send_data(data_size);
			end
			END_DIR_THEN_ZERO: send_zero_record();
			default: repeat (512) send_byte(8'($urandom));
		endcase
		no_gaps = 1'b0;
		repeat (TAIL_BYTES) send_byte(8'($urandom));

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
